@@ rtl/core/ljpf_pkg.sv @@
// Shared types, constants and helpers for the Lennard-Jones pair force pipeline.
// No dependencies; every other file in rtl/core except ljpf_delay refers to this package.
`default_nettype none
package ljpf_pkg;

  localparam int POS_W        = 32;
  localparam int VAL_W        = 64;
  localparam int DR_W         = 33;
  localparam int CFG_IDX_W    = 3;
  localparam int MUL_LAT      = 4;
  localparam int POS_FRAC_DEF = 16;
  localparam int VAL_FRAC_DEF = 32;

  localparam logic signed [VAL_W-1:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] S64_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] TW_LIMIT = S64_MAX / 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA_POW6   = 3'd0,
    CFG_CUTOFF_SQ    = 3'd1,
    CFG_ENERGY_SHIFT = 3'd2,
    CFG_FOUR_EPSILON = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                   valid;
    logic                   live;
    logic                   loc;
    logic signed [DR_W-1:0] dr_x;
    logic signed [DR_W-1:0] dr_y;
    logic signed [DR_W-1:0] dr_z;
    logic [VAL_W-2:0]       r2;
  } front_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } sres_t;

  // saturating signed subtract a - b
  function automatic sres_t ssub(input logic signed [VAL_W-1:0] a,
                                 input logic signed [VAL_W-1:0] b);
    sres_t            r;
    logic [VAL_W-1:0] d;
    d = a - b;
    r.val = d;
    r.sat = 1'b0;
    if (!a[VAL_W-1] && b[VAL_W-1] && d[VAL_W-1]) begin
      r.val = S64_MAX;
      r.sat = 1'b1;
    end else if (a[VAL_W-1] && !b[VAL_W-1] && !d[VAL_W-1]) begin
      r.val = S64_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ljpf_delay.sv @@
// Fixed-depth register delay line for sideband and operand alignment.
// Depends on nothing; depth must be at least one.
`default_nettype none
module ljpf_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) taps[k] <= '0;
    end else begin
      taps[0] <= din;
      for (int k = 1; k < D; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[D-1];

endmodule
`default_nettype wire

@@ rtl/core/ljpf_smul.sv @@
// Four-stage signed 64x64 multiplier: product shifted right by SH, truncated
// toward zero, saturated to 64 bits. Depends on ljpf_pkg.
`default_nettype none
module ljpf_smul #(
  parameter int SH = 32
) (
  input  wire logic                              clk,
  input  wire logic signed [ljpf_pkg::VAL_W-1:0] a,
  input  wire logic signed [ljpf_pkg::VAL_W-1:0] b,
  output logic signed      [ljpf_pkg::VAL_W-1:0] p,
  output logic                                   sat
);

  localparam int W = ljpf_pkg::VAL_W;
  localparam int H = W / 2;

  logic         neg0, neg1, neg2;
  logic [W-1:0] ma, mb;
  logic [W-1:0] pll, plh, phl, phh;
  logic [W-1:0] m2;
  logic         sat2;

  logic [2*W-1:0] full;
  logic [2*W-1:0] shifted;
  logic [W-1:0]   lim;
  logic           over;

  always_comb begin
    full    = {phh, pll} + ({{W{1'b0}}, plh} << H) + ({{W{1'b0}}, phl} << H);
    shifted = full >> SH;
    lim     = neg1 ? ljpf_pkg::S64_MIN : ljpf_pkg::S64_MAX;
    over    = (|shifted[2*W-1:W]) || (shifted[W-1:0] > lim);
  end

  always_ff @(posedge clk) begin
    neg0 <= a[W-1] ^ b[W-1];
    ma   <= a[W-1] ? W'(-a) : W'(a);
    mb   <= b[W-1] ? W'(-b) : W'(b);
    neg1 <= neg0;
    pll  <= W'(ma[H-1:0] * mb[H-1:0]);
    plh  <= W'(ma[H-1:0] * mb[W-1:H]);
    phl  <= W'(ma[W-1:H] * mb[H-1:0]);
    phh  <= W'(ma[W-1:H] * mb[W-1:H]);
    neg2 <= neg1;
    m2   <= over ? lim : shifted[W-1:0];
    sat2 <= over;
    p    <= neg2 ? -m2 : m2;
    sat  <= sat2;
  end

endmodule
`default_nettype wire

@@ rtl/core/ljpf_recip.sv @@
// Pipelined restoring divider: floor(2^(2V) / d), one quotient bit per stage,
// saturating at the top of the signed 64-bit range. Depends on ljpf_pkg.
`default_nettype none
module ljpf_recip #(
  parameter int V = ljpf_pkg::VAL_FRAC_DEF
) (
  input  wire logic                              clk,
  input  wire logic [ljpf_pkg::VAL_W-2:0]        d,
  output logic signed [ljpf_pkg::VAL_W-1:0]      inv,
  output logic                                   sat
);

  localparam int W  = ljpf_pkg::VAL_W;
  localparam int NB = 2 * V + 1;

  logic [W-2:0] rem_s  [NB+1];
  logic [W-2:0] d_s    [NB+1];
  logic [W-2:0] q_s    [NB+1];
  logic         over_s [NB+1];

  assign rem_s[0]  = '0;
  assign d_s[0]    = d;
  assign q_s[0]    = '0;
  assign over_s[0] = 1'b0;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int I = 2 * V - k;
    logic [W-1:0] r_try;
    logic         ge;
    logic [W-2:0] rem_r, d_r, q_r;
    logic         over_r;

    assign r_try = {rem_s[k], 1'(k == 0)};
    assign ge    = r_try >= {1'b0, d_s[k]};

    always_ff @(posedge clk) begin
      rem_r <= ge ? (W-1)'(r_try - {1'b0, d_s[k]}) : r_try[W-2:0];
      d_r   <= d_s[k];
    end

    if (I >= W - 1) begin : g_hi
      always_ff @(posedge clk) begin
        q_r    <= q_s[k];
        over_r <= over_s[k] | ge;
      end
    end else begin : g_lo
      always_ff @(posedge clk) begin
        q_r    <= q_s[k] | ((W-1)'(ge) << I);
        over_r <= over_s[k];
      end
    end

    assign rem_s[k+1]  = rem_r;
    assign d_s[k+1]    = d_r;
    assign q_s[k+1]    = q_r;
    assign over_s[k+1] = over_r;
  end

  assign inv = over_s[NB] ? ljpf_pkg::S64_MAX : {1'b0, q_s[NB]};
  assign sat = over_s[NB];

endmodule
`default_nettype wire

@@ rtl/core/ljpf_front.sv @@
// Front end: skip test, displacement, squared distance and cutoff check over
// five register stages. Depends on ljpf_pkg.
`default_nettype none
module ljpf_front #(
  parameter int P = ljpf_pkg::POS_FRAC_DEF,
  parameter int V = ljpf_pkg::VAL_FRAC_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              valid_in,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_i_x,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_i_y,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_i_z,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_j_x,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_j_y,
  input  wire logic signed [ljpf_pkg::POS_W-1:0] pos_j_z,
  input  wire logic [ljpf_pkg::POS_W-1:0]        id_i,
  input  wire logic [ljpf_pkg::POS_W-1:0]        id_j,
  input  wire logic                              partner_local,
  input  wire logic [ljpf_pkg::VAL_W-2:0]        cutoff_sq,
  output ljpf_pkg::front_t                       fout
);

  localparam int DW  = ljpf_pkg::DR_W;
  localparam int SQW = 2 * DW;
  localparam int SUW = SQW + 2;
  localparam int SH  = 2 * P - V;
  localparam int NSH = (SH < 0) ? -SH : 0;
  localparam int RW  = SUW + NSH;

  typedef struct packed {
    logic valid;
    logic skip;
    logic loc;
  } ctl_t;

  ctl_t                 c1, c2, c3, c4;
  logic signed [DW-1:0] dx1, dy1, dz1, dx2, dy2, dz2, dx3, dy3, dz3, dx4, dy4, dz4;
  logic [DW-1:0]        mx2, my2, mz2;
  logic [SQW-1:0]       sx3, sy3, sz3;
  logic [SUW-1:0]       sum4;
  logic [RW-1:0]        r2w;
  logic                 big;
  logic [ljpf_pkg::VAL_W-2:0] r2v;
  logic                 valid5, live5, loc5;
  logic signed [DW-1:0] drx5, dry5, drz5;
  logic [ljpf_pkg::VAL_W-2:0] r2_5;

  if (SH >= 0) begin : g_shr
    assign r2w = sum4 >> SH;
  end else begin : g_shl
    assign r2w = {sum4, {NSH{1'b0}}};
  end
  assign big = |r2w[RW-1:ljpf_pkg::VAL_W-1];
  assign r2v = r2w[ljpf_pkg::VAL_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      valid5 <= 1'b0;
      live5  <= 1'b0;
    end else begin
      c1.valid <= valid_in;
      c1.skip  <= partner_local && (id_j <= id_i);
      c1.loc   <= partner_local;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      valid5 <= c4.valid;
      live5  <= c4.valid && !c4.skip && !big && (r2v != '0) && (r2v <= cutoff_sq);
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= DW'(pos_i_x) - DW'(pos_j_x);
    dy1 <= DW'(pos_i_y) - DW'(pos_j_y);
    dz1 <= DW'(pos_i_z) - DW'(pos_j_z);
    mx2 <= dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
    my2 <= dy1[DW-1] ? DW'(-dy1) : DW'(dy1);
    mz2 <= dz1[DW-1] ? DW'(-dz1) : DW'(dz1);
    {dx2, dy2, dz2} <= {dx1, dy1, dz1};
    sx3 <= SQW'(mx2 * mx2);
    sy3 <= SQW'(my2 * my2);
    sz3 <= SQW'(mz2 * mz2);
    {dx3, dy3, dz3} <= {dx2, dy2, dz2};
    sum4 <= SUW'(sx3) + SUW'(sy3) + SUW'(sz3);
    {dx4, dy4, dz4} <= {dx3, dy3, dz3};
    loc5 <= c4.loc;
    drx5 <= dx4;
    dry5 <= dy4;
    drz5 <= dz4;
    r2_5 <= r2v;
  end

  assign fout = '{valid: valid5, live: live5, loc: loc5,
                  dr_x: drx5, dr_y: dry5, dr_z: drz5, r2: r2_5};

endmodule
`default_nettype wire

@@ rtl/core/lennard_jones_pair_force_top.sv @@
// Lennard-Jones 12-6 pair force engine, top level: config registers, front end,
// divider, multiplier chain. Depends on ljpf_pkg and all ljpf_* modules.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  pair in  | start, busy (transfer when  | pos_i_*, pos_j_*, id_i, id_j,
//           | start & !busy)              | partner_local
//  result   | strobe (one cycle)          | interacts, force_*, atom_energy_half,
//           |                             | sum_energy_share, saturated
//  config   | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// One pair is taken every cycle; busy stays low. Each pair passes through
// the five-stage front end, the one-bit-per-stage divider, seven chained
// four-stage multipliers and the output register. Synchronous reset clears
// all valid bits and the config registers. The receiver cannot stall, so
// the pipeline never holds.
`default_nettype none
module lennard_jones_pair_force_top #(
  parameter int POS_FRAC_BITS = ljpf_pkg::POS_FRAC_DEF,
  parameter int VAL_FRAC_BITS = ljpf_pkg::VAL_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_i_x,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_i_y,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_i_z,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_j_x,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_j_y,
  input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_j_z,
  input  wire logic [ljpf_pkg::POS_W-1:0]            id_i,
  input  wire logic [ljpf_pkg::POS_W-1:0]            id_j,
  input  wire logic                                  partner_local,
  output logic                                       strobe,
  output logic                                       interacts,
  output logic signed [ljpf_pkg::VAL_W-1:0]          force_x,
  output logic signed [ljpf_pkg::VAL_W-1:0]          force_y,
  output logic signed [ljpf_pkg::VAL_W-1:0]          force_z,
  output logic signed [ljpf_pkg::VAL_W-1:0]          atom_energy_half,
  output logic signed [ljpf_pkg::VAL_W-1:0]          sum_energy_share,
  output logic                                       saturated,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ljpf_pkg::VAL_W-1:0]            cfg_data
);

  localparam int W   = ljpf_pkg::VAL_W;
  localparam int DW  = ljpf_pkg::DR_W;
  localparam int L   = ljpf_pkg::MUL_LAT;
  localparam int NB  = 2 * VAL_FRAC_BITS + 1;
  localparam int LAT = 5 + NB + 7 * L + 1;
  localparam logic signed [W-1:0] ONE = W'(1) << VAL_FRAC_BITS;
  localparam logic signed [W-1:0] SIX = W'(6) << VAL_FRAC_BITS;

  typedef struct packed {
    logic valid;
    logic live;
    logic loc;
  } ctl_t;

  // configuration registers
  logic [W-2:0]        sigma_pow6, cutoff_sq, four_epsilon;
  logic signed [W-1:0] energy_shift;
  logic signed [W-1:0] sigma_s, four_eps_s;

  assign cfg_ready  = 1'b1;
  assign busy       = 1'b0;
  assign sigma_s    = {1'b0, sigma_pow6};
  assign four_eps_s = {1'b0, four_epsilon};

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_pow6   <= '0;
      cutoff_sq    <= '0;
      energy_shift <= '0;
      four_epsilon <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ljpf_pkg::cfg_idx_t'(cfg_index))
        ljpf_pkg::CFG_SIGMA_POW6:   sigma_pow6   <= cfg_data[W-2:0];
        ljpf_pkg::CFG_CUTOFF_SQ:    cutoff_sq    <= cfg_data[W-2:0];
        ljpf_pkg::CFG_ENERGY_SHIFT: energy_shift <= cfg_data;
        ljpf_pkg::CFG_FOUR_EPSILON: four_epsilon <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // front end and reciprocal
  ljpf_pkg::front_t f_out, s0;
  logic [$bits(ljpf_pkg::front_t)-1:0] s0_raw;
  logic signed [W-1:0] inv;
  logic                inv_sat;

  ljpf_front #(.P(POS_FRAC_BITS), .V(VAL_FRAC_BITS)) u_front (
    .clk, .rst, .valid_in(start && !busy),
    .pos_i_x, .pos_i_y, .pos_i_z, .pos_j_x, .pos_j_y, .pos_j_z,
    .id_i, .id_j, .partner_local, .cutoff_sq, .fout(f_out)
  );

  ljpf_recip #(.V(VAL_FRAC_BITS)) u_recip (
    .clk, .d(f_out.r2), .inv, .sat(inv_sat)
  );

  ljpf_delay #(.W($bits(ljpf_pkg::front_t)), .D(NB)) u_dly_s0 (
    .clk, .rst, .din(f_out), .dout(s0_raw)
  );
  assign s0 = ljpf_pkg::front_t'(s0_raw);

  // inv^3 and r6
  logic signed [W-1:0] t1, t2, r6, inv_d1, inv_d4;
  logic                s_m1, s_m2, s_m3, sat0_d, sat1, sat1_d, sat2, sat2_d, sat3;

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_m1 (.clk, .a(inv), .b(inv), .p(t1), .sat(s_m1));
  ljpf_delay #(.W(W), .D(L)) u_dly_inv1 (.clk, .rst, .din(inv), .dout(inv_d1));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat0 (.clk, .rst, .din(inv_sat), .dout(sat0_d));
  assign sat1 = sat0_d | s_m1;

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_m2 (.clk, .a(t1), .b(inv_d1), .p(t2), .sat(s_m2));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat1 (.clk, .rst, .din(sat1), .dout(sat1_d));
  assign sat2 = sat1_d | s_m2;

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_m3 (.clk, .a(sigma_s), .b(t2), .p(r6), .sat(s_m3));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat2 (.clk, .rst, .din(sat2), .dout(sat2_d));
  assign sat3 = sat2_d | s_m3;

  // r6 - 1 and 12*r6 - 6
  ljpf_pkg::sres_t     a_res, tw_res;
  logic signed [W-1:0] tw12_next;
  logic                tw12_sat;
  logic signed [W-1:0] a_x, r6_x, tw12_x, tw_x2;
  logic                satx, satx2;

  always_comb begin
    a_res = ljpf_pkg::ssub(r6, ONE);
    if (r6 > ljpf_pkg::TW_LIMIT) begin
      tw12_next = ljpf_pkg::S64_MAX;
      tw12_sat  = 1'b1;
    end else begin
      tw12_next = (r6 <<< 3) + (r6 <<< 2);
      tw12_sat  = 1'b0;
    end
    tw_res = ljpf_pkg::ssub(tw12_x, SIX);
  end

  always_ff @(posedge clk) begin
    a_x    <= a_res.val;
    r6_x   <= r6;
    tw12_x <= tw12_next;
    satx   <= sat3 | a_res.sat | tw12_sat;
    tw_x2  <= tw_res.val;
    satx2  <= satx | tw_res.sat;
  end

  // force factor chain
  logic signed [W-1:0] k1, k2, k3, tw_d;
  logic                s_k1, s_k2, s_k3, satx2_d, sat4, sat4_d, sat5, sat5_d, sat6, sat6_d;

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_k1 (.clk, .a(four_eps_s), .b(r6), .p(k1), .sat(s_k1));
  ljpf_delay #(.W(1), .D(L-2)) u_dly_satx2 (.clk, .rst, .din(satx2), .dout(satx2_d));
  assign sat4 = satx2_d | s_k1;

  ljpf_delay #(.W(W), .D(3*L)) u_dly_inv4 (.clk, .rst, .din(inv_d1), .dout(inv_d4));
  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_k2 (.clk, .a(k1), .b(inv_d4), .p(k2), .sat(s_k2));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat4 (.clk, .rst, .din(sat4), .dout(sat4_d));
  assign sat5 = sat4_d | s_k2;

  ljpf_delay #(.W(W), .D(2*L-2)) u_dly_tw (.clk, .rst, .din(tw_x2), .dout(tw_d));
  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_k3 (.clk, .a(k2), .b(tw_d), .p(k3), .sat(s_k3));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat5 (.clk, .rst, .din(sat5), .dout(sat5_d));
  assign sat6 = sat5_d | s_k3;

  // force components
  logic signed [DW-1:0] drx_d, dry_d, drz_d;
  logic signed [W-1:0]  fx, fy, fz;
  logic                 s_fx, s_fy, s_fz, sat7;

  ljpf_delay #(.W(3*DW), .D(6*L)) u_dly_dr (
    .clk, .rst, .din({s0.dr_x, s0.dr_y, s0.dr_z}), .dout({drx_d, dry_d, drz_d})
  );
  ljpf_smul #(.SH(POS_FRAC_BITS)) u_fx (.clk, .a(k3), .b(W'(drx_d)), .p(fx), .sat(s_fx));
  ljpf_smul #(.SH(POS_FRAC_BITS)) u_fy (.clk, .a(k3), .b(W'(dry_d)), .p(fy), .sat(s_fy));
  ljpf_smul #(.SH(POS_FRAC_BITS)) u_fz (.clk, .a(k3), .b(W'(drz_d)), .p(fz), .sat(s_fz));
  ljpf_delay #(.W(1), .D(L)) u_dly_sat6 (.clk, .rst, .din(sat6), .dout(sat6_d));
  assign sat7 = sat6_d | s_fx | s_fy | s_fz;

  // energy chain
  ljpf_pkg::sres_t     esub_res;
  logic signed [W-1:0] e1, e_reg, e4, e4_d;
  logic                s_e1, s_e4, se, se_d, seb, seb_d;

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_e1 (.clk, .a(r6_x), .b(a_x), .p(e1), .sat(s_e1));
  assign esub_res = ljpf_pkg::ssub(e1, energy_shift);

  always_ff @(posedge clk) begin
    e_reg <= esub_res.val;
    se    <= s_e1 | esub_res.sat;
  end

  ljpf_smul #(.SH(VAL_FRAC_BITS)) u_e4 (.clk, .a(four_eps_s), .b(e_reg), .p(e4), .sat(s_e4));
  ljpf_delay #(.W(1), .D(L)) u_dly_se (.clk, .rst, .din(se), .dout(se_d));
  assign seb = se_d | s_e4;
  ljpf_delay #(.W(W+1), .D(2*L-2)) u_dly_e4 (
    .clk, .rst, .din({e4, seb}), .dout({e4_d, seb_d})
  );

  // control sideband to the output stage
  ctl_t c_in, c_out;
  assign c_in = '{valid: s0.valid, live: s0.live, loc: s0.loc};
  ljpf_delay #(.W($bits(ctl_t)), .D(7*L)) u_dly_ctl (
    .clk, .rst, .din(c_in), .dout(c_out)
  );

  logic signed [W-1:0] e4_adj, half;
  assign e4_adj = e4_d + W'(e4_d[W-1]);
  assign half   = e4_adj >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      interacts <= 1'b0;
    end else begin
      strobe    <= c_out.valid;
      interacts <= c_out.valid && c_out.live;
    end
  end

  // drop all payload for pairs that do not interact
  always_ff @(posedge clk) begin
    if (c_out.live) begin
      force_x          <= fx;
      force_y          <= fy;
      force_z          <= fz;
      atom_energy_half <= half;
      sum_energy_share <= c_out.loc ? e4_d : half;
      saturated        <= sat7 | seb_d;
    end else begin
      force_x          <= '0;
      force_y          <= '0;
      force_z          <= '0;
      atom_energy_half <= '0;
      sum_energy_share <= '0;
      saturated        <= 1'b0;
    end
  end

  a_int_strobe : assert property (@(posedge clk) disable iff (rst)
    interacts |-> strobe)
    else $error("interacts without strobe");

  a_strobe_lat : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, LAT))
    else $error("result without a transfer at the pipeline latency");

  a_zero_res : assert property (@(posedge clk) disable iff (rst)
    (strobe && !interacts) |-> (force_x == '0 && force_y == '0 && force_z == '0 &&
                                atom_energy_half == '0 && sum_energy_share == '0 &&
                                !saturated))
    else $error("non-interacting result carries data");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for lennard_jones_pair_force_top: drives pair transfers and
// register writes, and checks every result against an in-bench fixed-point predictor.
// Depends on ljpf_pkg and the RTL top level.
`default_nettype none
module tb;

  typedef struct {
    logic signed [31:0] pix, piy, piz, pjx, pjy, pjz;
    logic [31:0]        idi, idj;
    logic               loc;
  } pair_t;

  typedef struct {
    logic    interacts;
    longint  fx, fy, fz, ehalf, eshare;
    logic    sat;
  } lj_res_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_i_x = '0, pos_i_y = '0, pos_i_z = '0;
  logic signed [31:0] pos_j_x = '0, pos_j_y = '0, pos_j_z = '0;
  logic [31:0] id_i = '0, id_j = '0;
  logic partner_local = 1'b0;
  logic strobe, interacts, saturated;
  logic signed [63:0] force_x, force_y, force_z, atom_energy_half, sum_energy_share;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ljpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  lennard_jones_pair_force_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block's registers
  logic [63:0] sh_sigma6 = '0, sh_cutoff = '0, sh_foureps = '0;
  longint sh_shift = 0;

  pair_t   pair_q[$];
  lj_res_t force_q[$];
  int  errors = 0;
  int  cyc = 0;
  bit  xfer = 0, cfg_seen = 0;
  bit  calm = 0;

  function automatic logic [63:0] mag64(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint fixmul(longint a, longint b, int sh, inout bit sat);
    logic [127:0] p;
    logic [63:0]  lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    p = {64'b0, mag64(a)} * {64'b0, mag64(b)};
    p = p >> sh;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (p > {64'b0, lim}) begin
      p = {64'b0, lim};
      sat = 1;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint satsub(longint a, longint b, inout bit sat);
    longint r;
    r = a - b;
    if (a >= 0 && b < 0 && r < 0) begin
      sat = 1;
      return ljpf_pkg::S64_MAX;
    end
    if (a < 0 && b >= 0 && r >= 0) begin
      sat = 1;
      return ljpf_pkg::S64_MIN;
    end
    return r;
  endfunction

  function automatic lj_res_t lj_predict(pair_t p);
    lj_res_t      r;
    longint       dr[3];
    logic [127:0] r2, q;
    bit           sat;
    longint       inv, t, r6, e, e4, tw, k;
    r = '{default: 0};
    sat = 0;
    if (p.loc && p.idj <= p.idi) return r;
    dr[0] = longint'(p.pix) - longint'(p.pjx);
    dr[1] = longint'(p.piy) - longint'(p.pjy);
    dr[2] = longint'(p.piz) - longint'(p.pjz);
    r2 = '0;
    for (int m = 0; m < 3; m++) r2 += {64'b0, mag64(dr[m])} * {64'b0, mag64(dr[m])};
    if (r2[127:63] != 0) return r;
    if (r2 == 0 || r2[63:0] > sh_cutoff) return r;
    q = (128'd1 << 64) / r2;
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
      inv = ljpf_pkg::S64_MAX;
      sat = 1;
    end else inv = longint'(q[63:0]);
    t  = fixmul(inv, inv, 32, sat);
    t  = fixmul(t, inv, 32, sat);
    r6 = fixmul(longint'(sh_sigma6), t, 32, sat);
    e  = fixmul(r6, satsub(r6, 64'sd1 <<< 32, sat), 32, sat);
    e  = satsub(e, sh_shift, sat);
    e4 = fixmul(longint'(sh_foureps), e, 32, sat);
    if (r6 > ljpf_pkg::TW_LIMIT) begin
      tw = ljpf_pkg::S64_MAX;
      sat = 1;
    end else tw = r6 * 12;
    tw = satsub(tw, 64'sd6 <<< 32, sat);
    k = fixmul(longint'(sh_foureps), r6, 32, sat);
    k = fixmul(k, inv, 32, sat);
    k = fixmul(k, tw, 32, sat);
    r.interacts = 1'b1;
    r.fx = fixmul(k, dr[0], 16, sat);
    r.fy = fixmul(k, dr[1], 16, sat);
    r.fz = fixmul(k, dr[2], 16, sat);
    r.ehalf = e4 / 2;
    r.eshare = p.loc ? e4 : r.ehalf;
    r.sat = sat;
    return r;
  endfunction

  // sample register writes, transfers and results
  always @(posedge clk) begin
    lj_res_t w;
    pair_t   p;
    cyc <= cyc + 1;
    xfer <= start && !busy;
    cfg_seen <= cfg_valid && cfg_ready;
    if (!rst && cfg_valid && cfg_ready) begin
      case (ljpf_pkg::cfg_idx_t'(cfg_index))
        ljpf_pkg::CFG_SIGMA_POW6:   sh_sigma6 = {1'b0, cfg_data[62:0]};
        ljpf_pkg::CFG_CUTOFF_SQ:    sh_cutoff = {1'b0, cfg_data[62:0]};
        ljpf_pkg::CFG_ENERGY_SHIFT: sh_shift = longint'(cfg_data);
        ljpf_pkg::CFG_FOUR_EPSILON: sh_foureps = {1'b0, cfg_data[62:0]};
        default: ;
      endcase
    end
    if (!rst && start && !busy) begin
      p = '{pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z, id_i, id_j, partner_local};
      force_q.push_back(lj_predict(p));
    end
    if (!rst && strobe) begin
      if (force_q.size() == 0) begin
        $error("result with no pair outstanding");
        errors++;
      end else begin
        w = force_q.pop_front();
        if (interacts !== w.interacts) begin
          $error("interacts exp %0d got %0d", w.interacts, interacts); errors++;
        end
        if (force_x !== w.fx) begin
          $error("force_x exp %0d got %0d", w.fx, force_x); errors++;
        end
        if (force_y !== w.fy) begin
          $error("force_y exp %0d got %0d", w.fy, force_y); errors++;
        end
        if (force_z !== w.fz) begin
          $error("force_z exp %0d got %0d", w.fz, force_z); errors++;
        end
        if (atom_energy_half !== w.ehalf) begin
          $error("atom_energy_half exp %0d got %0d", w.ehalf, atom_energy_half); errors++;
        end
        if (sum_energy_share !== w.eshare) begin
          $error("sum_energy_share exp %0d got %0d", w.eshare, sum_energy_share); errors++;
        end
        if (saturated !== w.sat) begin
          $error("saturated exp %0d got %0d", w.sat, saturated); errors++;
        end
      end
    end
  end

  // pair driver: advance on a transfer, idle now and then
  always @(negedge clk) begin
    pair_t p;
    if (!rst && (!start || xfer)) begin
      if (pair_q.size() == 0 || (!calm && $urandom_range(0, 99) < 9)) start <= 1'b0;
      else begin
        p = pair_q.pop_front();
        start <= 1'b1;
        pos_i_x <= p.pix; pos_i_y <= p.piy; pos_i_z <= p.piz;
        pos_j_x <= p.pjx; pos_j_y <= p.pjy; pos_j_z <= p.pjz;
        id_i <= p.idi; id_j <= p.idj; partner_local <= p.loc;
      end
    end
  end

  always @(posedge clk) begin
    if (cyc > 200000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic reg_write(ljpf_pkg::cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic [63:0] s6, logic [63:0] cut, logic [63:0] shf, logic [63:0] fe);
    reg_write(ljpf_pkg::CFG_SIGMA_POW6, s6);
    reg_write(ljpf_pkg::CFG_CUTOFF_SQ, cut);
    reg_write(ljpf_pkg::CFG_ENERGY_SHIFT, shf);
    reg_write(ljpf_pkg::CFG_FOUR_EPSILON, fe);
  endtask

  task automatic drain();
    do @(negedge clk); while (pair_q.size() != 0 || force_q.size() != 0 || start);
    repeat (110) @(negedge clk);
  endtask

  function automatic pair_t mk(int ix, int iy, int iz, int jx, int jy, int jz,
                               logic [31:0] a, logic [31:0] b, logic l);
    pair_t p;
    p = '{ix, iy, iz, jx, jy, jz, a, b, l};
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    span;
    p.pix = $urandom; p.piy = $urandom; p.piz = $urandom;
    p.idi = $urandom; p.idj = $urandom; p.loc = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 2) p.idj = p.idi + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 9) < 8) begin
      span = $urandom_range(0, 3) == 0 ? (1 << 12) : (3 << 16);
      p.pjx = p.pix + $urandom_range(0, 2 * span) - span;
      p.pjy = p.piy + $urandom_range(0, 2 * span) - span;
      p.pjz = p.piz + $urandom_range(0, 2 * span) - span;
    end else begin
      p.pjx = $urandom; p.pjy = $urandom; p.pjz = $urandom;
    end
    return p;
  endfunction

  task automatic random_pairs(int n);
    repeat (n) pair_q.push_back(rand_pair());
    drain();
  endtask

  localparam int ONE = 1 << 16;

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // registers at reset: cutoff of zero leaves every pair outside
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 1, 2, 0));
    drain();
    setup(64'd1 << 32, 64'd9 << 32, 64'hFFFF_FFFF_FC00_0000, 64'd4 << 32);
    reg_write(ljpf_pkg::cfg_idx_t'(ljpf_pkg::CFG_FOUR_EPSILON + 2), '1);
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 5, 5, 1));               // local, equal ids
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 5, 4, 1));               // local, lower id
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 4, 5, 1));               // local, higher id
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 5, 4, 0));               // remote partner
    pair_q.push_back(mk(ONE, ONE, ONE, ONE, ONE, ONE, 1, 2, 0));     // zero distance
    pair_q.push_back(mk(0, 0, 0, 3 * ONE, 0, 0, 1, 2, 1));           // exactly at cutoff
    pair_q.push_back(mk(0, 0, 0, 3 * ONE + 1, 0, 0, 1, 2, 1));       // just outside
    pair_q.push_back(mk(0, 0, 0, 1, 0, 0, 1, 2, 0));                 // one LSB apart
    pair_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'hFFFF_FFFF, 0, 0));                        // r2 beyond 63 bits
    pair_q.push_back(mk(32'h8000_0000, 0, 0, 32'h8000_0000 + ONE, ONE, -ONE,
                        0, 32'hFFFF_FFFF, 1));
    pair_q.push_back(mk(0, -ONE / 2, ONE / 3, ONE, ONE, -ONE, 7, 9, 0));
    drain();
    calm = 1;
    random_pairs(150);
    calm = 0;
    random_pairs(150);
    // extremes: every register at its limit, saturation everywhere
    setup(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
          64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    pair_q.push_back(mk(0, 0, 0, 1, 0, 0, 1, 2, 0));
    pair_q.push_back(mk(0, 0, 0, ONE, 0, 0, 1, 2, 1));
    random_pairs(100);
    setup(64'd3 << 30, 64'd100 << 32, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1 << 28);
    random_pairs(100);
    setup({$urandom, $urandom}, 64'd36 << 32, {$urandom, $urandom}, {$urandom, $urandom});
    random_pairs(100);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/ljpf_pkg.sv
rtl/core/ljpf_delay.sv
rtl/core/ljpf_smul.sv
rtl/core/ljpf_recip.sv
rtl/core/ljpf_front.sv
rtl/core/lennard_jones_pair_force_top.sv
tb/tb.sv
